FILE: sv/amsq_pkg.sv
// shared types and constants of the adaptive mode signal qualifier
package amsq_pkg;

  // register map: index is paddr[2]
  localparam int unsigned RegIdxW = 1;
  localparam logic [RegIdxW-1:0] REG_SETTLE_MS       = 1'b0;
  localparam logic [RegIdxW-1:0] REG_FORCED_STRATEGY = 1'b1;

  localparam logic [15:0] SETTLE_MS_RESET = 16'd300;

  // strategy codes
  localparam logic [1:0] STRAT_COMBINED = 2'd0;
  localparam logic [1:0] STRAT_OPEN     = 2'd1;
  localparam logic [1:0] STRAT_CONV     = 2'd2;

  // bit of the conversion word that marks native mode
  localparam int unsigned CMODE_NATIVE_BIT = 0;

  // configuration seen by the core
  typedef struct packed {
    logic [15:0] settle_ms;
    logic [1:0]  forced;
    logic        load_strategy;
    logic [1:0]  load_value;
  } amsq_cfg_t;

  // one poll
  typedef struct packed {
    logic [31:0]        now_ms;
    logic [31:0]        source_id;
    logic               query_valid;
    logic signed [31:0] open_word;
    logic signed [31:0] conv_word;
  } amsq_item_t;

  // one decision plus status
  typedef struct packed {
    logic       native_mode;
    logic       settling;
    logic [1:0] active_strategy;
    logic       non_binary_seen;
  } amsq_result_t;

endpackage

FILE: sv/amsq_cfg.sv
// configuration registers behind the apb-style port
module amsq_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output amsq_pkg::amsq_cfg_t cfg_o
);
  import amsq_pkg::*;

  logic [15:0] settle_ms_q;
  logic [1:0]  forced_q;
  logic [1:0]  forced_wr;
  logic        wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // a code of 3 falls back to adaptive
  always_comb begin
    unique case (pwdata[1:0])
      STRAT_OPEN: forced_wr = STRAT_OPEN;
      STRAT_CONV: forced_wr = STRAT_CONV;
      default:    forced_wr = STRAT_COMBINED;
    endcase
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_ms_q <= SETTLE_MS_RESET;
      forced_q    <= STRAT_COMBINED;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SETTLE_MS:       settle_ms_q <= pwdata[15:0];
        REG_FORCED_STRATEGY: forced_q    <= forced_wr;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_SETTLE_MS:       prdata = {16'd0, settle_ms_q};
      REG_FORCED_STRATEGY: prdata = {30'd0, forced_q};
      default:             prdata = 32'd0;
    endcase
  end

  // a forced write also loads the learned strategy
  always_comb begin
    cfg_o.settle_ms     = settle_ms_q;
    cfg_o.forced        = forced_q;
    cfg_o.load_value    = forced_wr;
    cfg_o.load_strategy = wr_en && (reg_idx == REG_FORCED_STRATEGY)
                          && (forced_wr != STRAT_COMBINED);
  end

endmodule

FILE: sv/amsq_core.sv
// qualifier state and the single-pass update for one poll
module amsq_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  amsq_pkg::amsq_cfg_t    cfg_i,
  input  logic                   fire_i,
  input  amsq_pkg::amsq_item_t   item_i,
  output amsq_pkg::amsq_result_t result_o
);
  import amsq_pkg::*;

  logic [31:0]        last_source_q, last_source_d;
  logic [31:0]        src_change_time_q, src_change_time_d;
  logic               init_pending_q, init_pending_d;
  logic signed [31:0] last_open_q, last_open_d;
  logic signed [31:0] last_conv_q, last_conv_d;
  logic [63:0]        pending_pair_q, pending_pair_d;
  logic [31:0]        pending_time_q, pending_time_d;
  logic [1:0]         strategy_q, strategy_d;
  logic               non_binary_q, non_binary_d;
  logic signed [31:0] native_value_q, native_value_d;
  logic signed [31:0] pending_nb_q, pending_nb_d;
  logic [31:0]        nb_time_q, nb_time_d;
  logic               last_decision_q, last_decision_d;

  logic               ok;
  logic signed [31:0] op;
  logic signed [31:0] cv;
  logic [31:0]        settle32;

  assign ok       = (item_i.source_id != 32'd0) && item_i.query_valid;
  assign op       = ok ? item_i.open_word : -32'sd1;
  assign cv       = ok ? item_i.conv_word : -32'sd1;
  assign settle32 = {16'd0, cfg_i.settle_ms};

  // next state for one poll
  always_comb begin
    logic skip;
    logic op_chg;
    logic cv_chg;
    logic [63:0] key;
    logic [31:0] d_src;
    logic [31:0] d_pend;
    logic [31:0] d_nb;

    last_source_d     = last_source_q;
    src_change_time_d = src_change_time_q;
    init_pending_d    = init_pending_q;
    last_open_d       = last_open_q;
    last_conv_d       = last_conv_q;
    pending_pair_d    = pending_pair_q;
    pending_time_d    = pending_time_q;
    strategy_d        = strategy_q;
    non_binary_d      = non_binary_q;
    native_value_d    = native_value_q;
    pending_nb_d      = pending_nb_q;
    nb_time_d         = nb_time_q;
    last_decision_d   = last_decision_q;

    skip   = 1'b0;
    d_src  = item_i.now_ms - src_change_time_q;
    d_pend = item_i.now_ms - pending_time_q;
    d_nb   = item_i.now_ms - nb_time_q;
    key    = {op, cv};

    // source change and settle hold
    if (item_i.source_id != last_source_q) begin
      last_source_d     = item_i.source_id;
      src_change_time_d = item_i.now_ms;
      pending_pair_d    = 64'd0;
      pending_time_d    = 32'd0;
      pending_nb_d      = 32'sd0;
      nb_time_d         = 32'd0;
      init_pending_d    = 1'b1;
      skip              = 1'b1;
    end else if (init_pending_q) begin
      if (d_src < settle32) begin
        skip = 1'b1;
      end else begin
        last_open_d    = op;
        last_conv_d    = cv;
        init_pending_d = 1'b0;
      end
    end

    op_chg = (op != last_open_d);
    cv_chg = (cv != last_conv_d);

    // learning of the authoritative word
    if (!skip && ok && (cfg_i.forced == STRAT_COMBINED)) begin
      if (op_chg || cv_chg) begin
        if (key != pending_pair_q) begin
          pending_pair_d = key;
          pending_time_d = item_i.now_ms;
          skip           = 1'b1;
        end else if (d_pend < settle32) begin
          skip = 1'b1;
        end else if (cv_chg) begin
          if (strategy_d == STRAT_OPEN && non_binary_d) begin
            non_binary_d   = 1'b0;
            native_value_d = 32'sd0;
            pending_nb_d   = 32'sd0;
            nb_time_d      = 32'd0;
          end
          strategy_d = STRAT_CONV;
        end else begin
          if (strategy_d == STRAT_CONV && non_binary_d) begin
            non_binary_d = 1'b0;
          end
          strategy_d = STRAT_OPEN;
          if (op > 32'sd1) begin
            if (pending_nb_d != op) begin
              pending_nb_d = op;
              nb_time_d    = item_i.now_ms;
              skip         = 1'b1;
            end else if (d_nb < settle32) begin
              skip = 1'b1;
            end else begin
              non_binary_d   = 1'b1;
              native_value_d = op;
              pending_nb_d   = 32'sd0;
              nb_time_d      = 32'd0;
            end
          end else if (last_open_d >= 32'sd0 && last_open_d <= 32'sd1) begin
            if (non_binary_d) begin
              non_binary_d   = 1'b0;
              native_value_d = 32'sd0;
              pending_nb_d   = 32'sd0;
              nb_time_d      = 32'd0;
            end
          end else begin
            pending_nb_d = 32'sd0;
            nb_time_d    = 32'd0;
          end
        end
        if (!skip) begin
          last_open_d    = op;
          last_conv_d    = cv;
          pending_pair_d = 64'd0;
          pending_time_d = 32'd0;
        end
      end else begin
        pending_pair_d = 64'd0;
        pending_time_d = 32'd0;
      end
    end

    // decision
    if (ok && !init_pending_d) begin
      unique case (strategy_d)
        STRAT_OPEN: begin
          last_decision_d = non_binary_d ? (op == native_value_d) : (op != 32'sd0);
        end
        STRAT_CONV: last_decision_d = cv[CMODE_NATIVE_BIT];
        default: begin
          priority if (non_binary_d) last_decision_d = (op == native_value_d);
          else if (cv == 32'sd0)     last_decision_d = (op != 32'sd0);
          else if (op == 32'sd0)     last_decision_d = 1'b0;
          else                       last_decision_d = cv[CMODE_NATIVE_BIT];
        end
      endcase
    end
  end

  // result of this poll
  always_comb begin
    result_o.native_mode     = last_decision_d;
    result_o.settling        = init_pending_d;
    result_o.active_strategy = strategy_d;
    result_o.non_binary_seen = non_binary_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_source_q     <= 32'd0;
      src_change_time_q <= 32'd0;
      init_pending_q    <= 1'b0;
      last_open_q       <= 32'sd0;
      last_conv_q       <= 32'sd0;
      pending_pair_q    <= 64'd0;
      pending_time_q    <= 32'd0;
      strategy_q        <= STRAT_COMBINED;
      non_binary_q      <= 1'b0;
      native_value_q    <= 32'sd0;
      pending_nb_q      <= 32'sd0;
      nb_time_q         <= 32'd0;
      last_decision_q   <= 1'b0;
    end else if (cfg_i.load_strategy) begin
      strategy_q <= cfg_i.load_value;
    end else if (fire_i) begin
      last_source_q     <= last_source_d;
      src_change_time_q <= src_change_time_d;
      init_pending_q    <= init_pending_d;
      last_open_q       <= last_open_d;
      last_conv_q       <= last_conv_d;
      pending_pair_q    <= pending_pair_d;
      pending_time_q    <= pending_time_d;
      strategy_q        <= strategy_d;
      non_binary_q      <= non_binary_d;
      native_value_q    <= native_value_d;
      pending_nb_q      <= pending_nb_d;
      nb_time_q         <= nb_time_d;
      last_decision_q   <= last_decision_d;
    end
  end

endmodule

FILE: sv/adaptive_mode_signal_qualifier.sv
// top level: input register, qualifier core, result register, config port
//
// Each accepted poll gives exactly one result. A poll is taken into an input
// register and passes the combinational core into the result register when
// that is free; while out_ready_i is high one poll per cycle is sustained,
// the rate set by the one-pass core state update (settle timers, pending
// pair, learned strategy and native value). The result and input registers
// let a new request be taken while a finished result still waits. The user
// must write configuration through the apb port (settle_ms at 0x0,
// forced_strategy at 0x4) only while idle; the block does not enforce it.
module adaptive_mode_signal_qualifier (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        now_ms_i,
  input  logic [31:0]        source_id_i,
  input  logic               query_valid_i,
  input  logic signed [31:0] open_word_i,
  input  logic signed [31:0] conv_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               native_mode_o,
  output logic               settling_o,
  output logic [1:0]         active_strategy_o,
  output logic               non_binary_seen_o
);
  import amsq_pkg::*;

  amsq_cfg_t    cfg;
  amsq_item_t   item_q;
  amsq_result_t result_d, result_q;
  logic         in_valid_q;
  logic         out_valid_q;
  logic         adv;
  logic         take;

  amsq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign take       = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= take || (in_valid_q && !adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.now_ms      <= now_ms_i;
      item_q.source_id   <= source_id_i;
      item_q.query_valid <= query_valid_i;
      item_q.open_word   <= open_word_i;
      item_q.conv_word   <= conv_word_i;
    end
  end

  amsq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (adv),
    .item_i   (item_q),
    .result_o (result_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign native_mode_o     = result_q.native_mode;
  assign settling_o        = result_q.settling;
  assign active_strategy_o = result_q.active_strategy;
  assign non_binary_seen_o = result_q.non_binary_seen;

endmodule

FILE: tb/sv/tb_adaptive_mode_signal_qualifier.sv
// self-checking testbench for the adaptive mode signal qualifier
module tb_adaptive_mode_signal_qualifier;
  timeunit 1ns;
  timeprecision 1ps;

  import amsq_pkg::*;

  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned IDLE_LIMIT = 5000;
  // forced strategy code with no meaning of its own, falls back to adaptive
  localparam logic [1:0] STRAT_RESERVED = 2'd3;

  // keeps its own copy of the qualifier state and the queue of expected decisions
  class mode_scoreboard;
    bit [15:0]        settle;
    bit [1:0]         forced;
    bit [31:0]        cur_src;
    bit [31:0]        src_change_t;
    bit               settling;
    bit signed [31:0] held_open;
    bit signed [31:0] held_conv;
    bit [63:0]        cand_pair;
    bit [31:0]        cand_t;
    bit [1:0]         strat;
    bit               nb_latched;
    bit signed [31:0] native_val;
    bit signed [31:0] nb_cand;
    bit [31:0]        nb_cand_t;
    bit               decision;
    amsq_result_t     decision_q[$];
    int unsigned      errors;
    int unsigned      n_checked;

    function new();
      settle       = SETTLE_MS_RESET;
      forced       = STRAT_COMBINED;
      cur_src      = '0;
      src_change_t = '0;
      settling     = 1'b0;
      held_open    = '0;
      held_conv    = '0;
      cand_pair    = '0;
      cand_t       = '0;
      strat        = STRAT_COMBINED;
      decision     = 1'b0;
      errors       = 0;
      n_checked    = 0;
      drop_native();
    endfunction

    function void drop_native();
      nb_latched = 1'b0;
      native_val = '0;
      nb_cand    = '0;
      nb_cand_t  = '0;
    endfunction

    // elapsed time modulo 2^32 still below the settle time
    function bit too_early(bit [31:0] now, bit [31:0] since);
      bit [31:0] d;
      d = now - since;
      return d < {16'h0, settle};
    endfunction

    function void set_register(logic [RegIdxW-1:0] idx, logic [31:0] val);
      bit [1:0] f;
      if (idx == REG_SETTLE_MS) begin
        settle = val[15:0];
      end else begin
        f = val[1:0];
        forced = (f == STRAT_OPEN || f == STRAT_CONV) ? f : STRAT_COMBINED;
        if (forced != STRAT_COMBINED) strat = forced;
      end
    endfunction

    // advance the state by one accepted poll and queue the decision it gives
    function void take_poll(amsq_item_t p);
      bit               ok;
      bit               hold;
      bit               op_chg;
      bit               cv_chg;
      bit signed [31:0] op;
      bit signed [31:0] cv;
      bit [63:0]        key;
      amsq_result_t     r;
      ok   = (p.source_id != 0) && p.query_valid;
      op   = ok ? p.open_word : -32'sd1;
      cv   = ok ? p.conv_word : -32'sd1;
      hold = 1'b0;

      // source change restarts the settle hold
      if (p.source_id != cur_src) begin
        cur_src      = p.source_id;
        src_change_t = p.now_ms;
        cand_pair    = '0;
        cand_t       = '0;
        nb_cand      = '0;
        nb_cand_t    = '0;
        settling     = 1'b1;
        hold         = 1'b1;
      end else if (settling) begin
        if (too_early(p.now_ms, src_change_t)) begin
          hold = 1'b1;
        end else begin
          held_open = op;
          held_conv = cv;
          settling  = 1'b0;
        end
      end

      // learn the authoritative word from stable changes
      if (!hold && ok && forced == STRAT_COMBINED) begin
        op_chg = (op != held_open);
        cv_chg = (cv != held_conv);
        if (op_chg || cv_chg) begin
          key = {op, cv};
          if (key != cand_pair) begin
            cand_pair = key;
            cand_t    = p.now_ms;
            hold      = 1'b1;
          end else if (too_early(p.now_ms, cand_t)) begin
            hold = 1'b1;
          end else if (cv_chg) begin
            if (strat == STRAT_OPEN && nb_latched) drop_native();
            strat = STRAT_CONV;
          end else begin
            if (strat == STRAT_CONV && nb_latched) nb_latched = 1'b0;
            strat = STRAT_OPEN;
            if (op > 1) begin
              // non-binary open value must itself stay stable
              if (nb_cand != op) begin
                nb_cand   = op;
                nb_cand_t = p.now_ms;
                hold      = 1'b1;
              end else if (too_early(p.now_ms, nb_cand_t)) begin
                hold = 1'b1;
              end else begin
                nb_latched = 1'b1;
                native_val = op;
                nb_cand    = '0;
                nb_cand_t  = '0;
              end
            end else if (held_open >= 0 && held_open <= 1) begin
              if (nb_latched) drop_native();
            end else begin
              nb_cand   = '0;
              nb_cand_t = '0;
            end
          end
          if (!hold) begin
            held_open = op;
            held_conv = cv;
            cand_pair = '0;
            cand_t    = '0;
          end
        end else begin
          cand_pair = '0;
          cand_t    = '0;
        end
      end

      // decision, held when the poll is invalid or still settling
      if (ok && !settling) begin
        if (strat == STRAT_OPEN) begin
          decision = nb_latched ? (op == native_val) : (op != 0);
        end else if (strat == STRAT_CONV) begin
          decision = cv[CMODE_NATIVE_BIT];
        end else if (nb_latched) begin
          decision = (op == native_val);
        end else if (cv == 0) begin
          decision = (op != 0);
        end else if (op == 0) begin
          decision = 1'b0;
        end else begin
          decision = cv[CMODE_NATIVE_BIT];
        end
      end

      r.native_mode     = decision;
      r.settling        = settling;
      r.active_strategy = strat;
      r.non_binary_seen = nb_latched;
      decision_q.push_back(r);
    endfunction

    function int unsigned pending();
      return decision_q.size();
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_decision(amsq_result_t got);
      amsq_result_t want;
      if (decision_q.size() == 0) begin
        report("result with no request waiting");
        return;
      end
      want = decision_q.pop_front();
      if (got.native_mode !== want.native_mode)
        report($sformatf("result %0d native_mode %b, want %b",
                         n_checked, got.native_mode, want.native_mode));
      if (got.settling !== want.settling)
        report($sformatf("result %0d settling %b, want %b",
                         n_checked, got.settling, want.settling));
      if (got.active_strategy !== want.active_strategy)
        report($sformatf("result %0d active_strategy %0d, want %0d",
                         n_checked, got.active_strategy, want.active_strategy));
      if (got.non_binary_seen !== want.non_binary_seen)
        report($sformatf("result %0d non_binary_seen %b, want %b",
                         n_checked, got.non_binary_seen, want.non_binary_seen));
      n_checked++;
    endtask
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [2:0]         paddr         = '0;
  logic [31:0]        pwdata        = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [31:0]        now_ms_i      = '0;
  logic [31:0]        source_id_i   = '0;
  logic               query_valid_i = 1'b0;
  logic signed [31:0] open_word_i   = '0;
  logic signed [31:0] conv_word_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic               native_mode_o;
  logic               settling_o;
  logic [1:0]         active_strategy_o;
  logic               non_binary_seen_o;

  mode_scoreboard     sb = new();
  int unsigned        idle_cycles = 0;
  int unsigned        settle_cur  = SETTLE_MS_RESET;
  bit                 gap_on      = 1'b1;
  bit                 stall_on    = 1'b1;
  logic [31:0]        cur_t       = '0;
  logic [31:0]        cur_src     = 32'd1;
  logic signed [31:0] cur_op      = '0;
  logic signed [31:0] cur_cv      = '0;

  adaptive_mode_signal_qualifier dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .now_ms_i          (now_ms_i),
    .source_id_i       (source_id_i),
    .query_valid_i     (query_valid_i),
    .open_word_i       (open_word_i),
    .conv_word_i       (conv_word_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .native_mode_o     (native_mode_o),
    .settling_o        (settling_o),
    .active_strategy_o (active_strategy_o),
    .non_binary_seen_o (non_binary_seen_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // mostly short idle stretches, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] pick_source();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 32'd0;
    if (r < 30) return $urandom;
    return $urandom_range(4, 1);
  endfunction

  function automatic logic signed [31:0] pick_open();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 32'sd0;
    if (r < 50) return 32'sd1;
    if (r < 75) return $urandom_range(5, 2);
    if (r < 85) return -32'sd1;
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_conv();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return 32'sd0;
    if (r < 55) return 32'sd1;
    if (r < 80) return $urandom_range(15);
    return $urandom;
  endfunction

  // monitor: note accepted requests, check accepted results
  always @(posedge clk_i) begin
    amsq_result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.take_poll('{now_ms: now_ms_i, source_id: source_id_i,
                       query_valid: query_valid_i, open_word: open_word_i,
                       conv_word: conv_word_i});
      if (out_valid_o && out_ready_i) begin
        got.native_mode     = native_mode_o;
        got.settling        = settling_o;
        got.active_strategy = active_strategy_o;
        got.non_binary_seen = non_binary_seen_o;
        sb.check_decision(got);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_adaptive_mode_signal_qualifier: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin : out_ready_gen
    int unsigned n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (stall_on && $urandom_range(3) == 0) begin
        out_ready_i <= 1'b0;
        n = idle_len();
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      n = $urandom_range(8, 1);
      repeat (n) @(posedge clk_i);
    end
  end

  // one request, with an optional gap before it
  task automatic send_poll(amsq_item_t p);
    int unsigned gap;
    gap = (gap_on && $urandom_range(2) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    now_ms_i      <= p.now_ms;
    source_id_i   <= p.source_id;
    query_valid_i <= p.query_valid;
    open_word_i   <= p.open_word;
    conv_word_i   <= p.conv_word;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic poll(logic [31:0] t, logic [31:0] s, logic v,
                      logic signed [31:0] o, logic signed [31:0] c);
    send_poll('{now_ms: t, source_id: s, query_valid: v, open_word: o, conv_word: c});
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [RegIdxW-1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, val);
    if (idx == REG_SETTLE_MS) settle_cur = val[15:0];
    // go idle between transfers
    @(posedge clk_i);
  endtask

  // timeline built around the settle time, with source changes, word
  // changes that hold or bounce, and invalid polls
  task automatic random_poll();
    amsq_item_t  p;
    int unsigned r;
    int unsigned step;
    r = $urandom_range(99);
    if (r < 65) step = $urandom_range(settle_cur / 3 + 1);
    else if (r < 93) step = settle_cur + $urandom_range(settle_cur / 4 + 1);
    else if (r < 97) step = $urandom_range(3);
    else step = $urandom;
    cur_t = cur_t + step;
    if ($urandom_range(49) == 0) cur_src = pick_source();
    r = $urandom_range(99);
    if (r < 8) begin
      cur_op = pick_open();
    end else if (r < 14) begin
      cur_cv = pick_conv();
    end else if (r < 17) begin
      cur_op = pick_open();
      cur_cv = pick_conv();
    end
    p.now_ms      = cur_t;
    p.source_id   = cur_src;
    p.query_valid = ($urandom_range(24) != 0);
    p.open_word   = cur_op;
    p.conv_word   = cur_cv;
    // one-poll glitch that does not persist
    if (r >= 17 && r < 21) begin
      p.open_word = pick_open();
      p.conv_word = pick_conv();
    end
    send_poll(p);
  endtask

  task automatic run_phase(logic [31:0] settle_word, logic [1:0] strat_word,
                           int unsigned n, bit gaps, bit stalls, bit pause_mid);
    drain_results();
    apb_write(REG_SETTLE_MS, settle_word);
    apb_write(REG_FORCED_STRATEGY, {30'h0, strat_word});
    gap_on   = gaps;
    stall_on = stalls;
    for (int unsigned i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain_results();
      random_poll();
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk under the reset configuration (settle 300, adaptive)
    poll(32'd0, 32'd0, 1'b1, 32'sh7FFFFFFF, 32'sh80000000);   // no source
    poll(32'd10, 32'd5, 1'b1, 32'sd0, 32'sd0);                // source change
    poll(32'd100, 32'd5, 1'b1, 32'sd0, 32'sd0);
    poll(32'd400, 32'd5, 1'b1, 32'sd0, 32'sd0);               // settled
    poll(32'd450, 32'd5, 1'b1, 32'sd1, 32'sd0);
    poll(32'd800, 32'd5, 1'b1, 32'sd1, 32'sd0);               // open word learned
    poll(32'd900, 32'd5, 1'b1, 32'sd5, 32'sd0);
    poll(32'd1300, 32'd5, 1'b1, 32'sd5, 32'sd0);
    poll(32'd1700, 32'd5, 1'b1, 32'sd5, 32'sd0);              // non-binary latched
    poll(32'd1800, 32'd5, 1'b1, 32'sd0, 32'sd0);              // matches cleared pair
    poll(32'd1850, 32'd5, 1'b1, 32'sd0, 32'sd1);
    poll(32'd2200, 32'd5, 1'b1, 32'sd0, 32'sd1);              // conversion word learned
    poll(32'd2300, 32'd5, 1'b0, 32'sd0, 32'sd0);              // query invalid
    poll(32'hFFFFFF00, 32'd5, 1'b1, 32'sh80000000, 32'shFFFFFFFE);
    poll(32'h00000100, 32'd5, 1'b1, 32'sh80000000, 32'shFFFFFFFE); // time wrap
    poll(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    poll(32'h0000012B, 32'hFFFFFFFF, 1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF); // exact settle
    poll(32'h00000200, 32'd0, 1'b1, 32'sd3, 32'sd3);
    cur_t = 32'h00000300;

    // configuration sweep with random traffic
    run_phase(32'd300, STRAT_COMBINED, 200, 1'b1, 1'b1, 1'b0);
    run_phase(32'd0, STRAT_COMBINED, 100, 1'b0, 1'b0, 1'b0);
    run_phase(32'd20, STRAT_OPEN, 100, 1'b1, 1'b0, 1'b0);
    run_phase(32'h0000FFFF, STRAT_CONV, 80, 1'b0, 1'b1, 1'b0);
    run_phase(32'd5, STRAT_RESERVED, 150, 1'b1, 1'b1, 1'b0);
    run_phase({16'($urandom), 16'($urandom_range(1000, 1))}, STRAT_COMBINED,
              150, 1'b1, 1'b1, 1'b1);
    run_phase(32'd1, STRAT_CONV, 30, 1'b1, 1'b1, 1'b0);
    run_phase(32'd40, STRAT_COMBINED, 40, 1'b0, 1'b1, 1'b0);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_adaptive_mode_signal_qualifier: done, clean");
    end else begin
      $display("tb_adaptive_mode_signal_qualifier: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/amsq_pkg.sv
sv/amsq_cfg.sv
sv/amsq_core.sv
sv/adaptive_mode_signal_qualifier.sv
tb/sv/tb_adaptive_mode_signal_qualifier.sv
